// File: rtl/vmes_pkg.sv
// ----------------------------------------------------------------------------
// vmes_pkg
// Widths, codes and shared types for the von Mises equivalent stress block.
// Inputs and result share the same number of fraction bits, so the datapath
// works on raw integers and needs no fraction-dependent scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package vmes_pkg;

    localparam int IN_W    = 32;              // tensor component width
    localparam int DIFF_W  = IN_W + 1;        // diagonal difference magnitude
    localparam int SQ_W    = 2 * IN_W;        // one square
    localparam int DSUM_W  = SQ_W + 2;        // sum of three diagonal squares
    localparam int OUT_BITS = 36;             // root width
    localparam int RAD_W   = 2 * OUT_BITS;    // radicand width
    localparam int REM_W   = OUT_BITS + 2;    // partial remainder width
    localparam int CNT_W   = 5;               // component count register width
    localparam int FRONT_STAGES = 4;

    localparam logic [CNT_W-1:0] VALID_COUNT = CNT_W'(9);

    // Data handed from cell to cell along the root chain
    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [OUT_BITS-1:0] root;
        logic [RAD_W-1:0]    rad;
        logic                bad;
        logic                last;
    } t_cell_data;

endpackage

`default_nettype wire

// File: rtl/vmes_in_if.sv
// ----------------------------------------------------------------------------
// vmes_in_if
// Request channel carrying one stress tensor and its last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface vmes_in_if;
    import vmes_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] s_xx;
    logic signed [IN_W-1:0] s_xy;
    logic signed [IN_W-1:0] s_xz;
    logic signed [IN_W-1:0] s_yy;
    logic signed [IN_W-1:0] s_yz;
    logic signed [IN_W-1:0] s_zz;
    logic                   last_in;

    modport source (output valid, s_xx, s_xy, s_xz, s_yy, s_yz, s_zz, last_in,
                    input ready);
    modport sink   (input valid, s_xx, s_xy, s_xz, s_yy, s_yz, s_zz, last_in,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/vmes_out_if.sv
// ----------------------------------------------------------------------------
// vmes_out_if
// Result channel carrying the equivalent stress and its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface vmes_out_if;
    import vmes_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] effective_stress;
    logic                saturated;
    logic                bad_format;
    logic                last_out;

    modport source (output valid, effective_stress, saturated, bad_format, last_out,
                    input ready);
    modport sink   (input valid, effective_stress, saturated, bad_format, last_out,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/vmes_front.sv
// ----------------------------------------------------------------------------
// vmes_front
// Four-stage front end: differences and magnitudes, squares, sums, and the
// radicand 3*J2 = (sum of squared diagonal differences)/2 + 3*(shear squares).
// ----------------------------------------------------------------------------
`default_nettype none

module vmes_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire [vmes_pkg::IN_W-1:0] i_s_xx,
    input  wire [vmes_pkg::IN_W-1:0] i_s_xy,
    input  wire [vmes_pkg::IN_W-1:0] i_s_xz,
    input  wire [vmes_pkg::IN_W-1:0] i_s_yy,
    input  wire [vmes_pkg::IN_W-1:0] i_s_yz,
    input  wire [vmes_pkg::IN_W-1:0] i_s_zz,
    input  wire                      i_bad,
    input  wire                      i_last,
    output logic                     o_valid,
    input  wire                      i_ready,
    output vmes_pkg::t_cell_data     o_data
);
    import vmes_pkg::*;

    logic [FRONT_STAGES-1:0] r_v;
    logic [FRONT_STAGES:0]   w_rdy;
    logic [FRONT_STAGES-1:0] r_bad;
    logic [FRONT_STAGES-1:0] r_last;

    // stage 1
    logic [DIFF_W-1:0] r_d1, r_d2, r_d3;
    logic [IN_W-1:0]   r_x1, r_x2, r_x3;
    // stage 2
    logic [SQ_W-1:0]   r_sd1, r_sd2, r_sd3, r_sx1, r_sx2, r_sx3;
    // stage 3
    logic [DSUM_W-1:0] r_dsum;
    logic [SQ_W-1:0]   r_shear;
    // stage 4
    logic [RAD_W-1:0]  r_q;

    logic [DIFF_W-1:0]   n_d1, n_d2, n_d3;
    logic [IN_W-1:0]     n_x1, n_x2, n_x3;
    logic [2*DIFF_W-1:0] w_p1, w_p2, w_p3;
    logic [DSUM_W-1:0]   n_dsum;
    logic [RAD_W-1:0]    n_q;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [IN_W-1:0] a,
                                                    input logic [IN_W-1:0] b);
        logic [DIFF_W-1:0] d;
        d = {a[IN_W-1], a} - {b[IN_W-1], b};
        return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    endfunction

    function automatic logic [IN_W-1:0] abs_val(input logic [IN_W-1:0] a);
        return a[IN_W-1] ? (~a + IN_W'(1)) : a;
    endfunction

    // a stage loads when it is empty or its content moves on
    always_comb begin
        w_rdy[FRONT_STAGES] = i_ready;
        for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        n_d1 = abs_diff(i_s_xx, i_s_yy);
        n_d2 = abs_diff(i_s_yy, i_s_zz);
        n_d3 = abs_diff(i_s_zz, i_s_xx);
        n_x1 = abs_val(i_s_xy);
        n_x2 = abs_val(i_s_xz);
        n_x3 = abs_val(i_s_yz);
        w_p1 = r_d1 * r_d1;
        w_p2 = r_d2 * r_d2;
        w_p3 = r_d3 * r_d3;
        n_dsum = DSUM_W'(r_sd1) + DSUM_W'(r_sd2) + DSUM_W'(r_sd3);
        // the diagonal sum is always even, so the halving is exact
        n_q = RAD_W'(r_dsum[DSUM_W-1:1]) + RAD_W'({r_shear, 1'b0}) + RAD_W'(r_shear);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < FRONT_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_d1      <= n_d1;
            r_d2      <= n_d2;
            r_d3      <= n_d3;
            r_x1      <= n_x1;
            r_x2      <= n_x2;
            r_x3      <= n_x3;
            r_bad[0]  <= i_bad;
            r_last[0] <= i_last;
        end
        if (w_rdy[1] && r_v[0]) begin
            r_sd1     <= w_p1[SQ_W-1:0];
            r_sd2     <= w_p2[SQ_W-1:0];
            r_sd3     <= w_p3[SQ_W-1:0];
            r_sx1     <= r_x1 * r_x1;
            r_sx2     <= r_x2 * r_x2;
            r_sx3     <= r_x3 * r_x3;
            r_bad[1]  <= r_bad[0];
            r_last[1] <= r_last[0];
        end
        if (w_rdy[2] && r_v[1]) begin
            r_dsum    <= n_dsum;
            r_shear   <= r_sx1 + r_sx2 + r_sx3;
            r_bad[2]  <= r_bad[1];
            r_last[2] <= r_last[1];
        end
        if (w_rdy[3] && r_v[2]) begin
            r_q       <= n_q;
            r_bad[3]  <= r_bad[2];
            r_last[3] <= r_last[2];
        end
    end

    assign o_ready     = w_rdy[0];
    assign o_valid     = r_v[FRONT_STAGES-1];
    assign o_data.rem  = '0;
    assign o_data.root = '0;
    assign o_data.rad  = r_q;
    assign o_data.bad  = r_bad[FRONT_STAGES-1];
    assign o_data.last = r_last[FRONT_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/vmes_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vmes_sqrt_cell
// One digit of the restoring square root: shift in two radicand bits,
// try 4*root+1 against the remainder, and pass the result to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module vmes_sqrt_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  vmes_pkg::t_cell_data i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output vmes_pkg::t_cell_data o_data
);
    import vmes_pkg::*;

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;
    logic [REM_W-1:0] w_rem_sh;
    logic [REM_W-1:0] w_trial;

    always_comb begin
        w_rem_sh = {i_data.rem[REM_W-3:0], i_data.rad[RAD_W-1 -: 2]};
        w_trial  = {i_data.root, 2'b01};
        n_data   = i_data;
        n_data.rad = {i_data.rad[RAD_W-3:0], 2'b00};
        if (w_rem_sh >= w_trial) begin
            n_data.rem  = w_rem_sh - w_trial;
            n_data.root = {i_data.root[OUT_BITS-2:0], 1'b1};
        end else begin
            n_data.rem  = w_rem_sh;
            n_data.root = {i_data.root[OUT_BITS-2:0], 1'b0};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/von_mises_effective_stress.sv
// ----------------------------------------------------------------------------
// von_mises_effective_stress
// Streaming von Mises equivalent stress, one symmetric tensor per request.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries the six components (signed fixed point) and last_in; a
//   request is taken on a clock edge with valid and ready high. o_out carries
//   effective_stress = floor(sqrt(3*J2)) in the same fixed-point scale, the
//   saturated and bad_format flags, and last_out.
//   i_cfg_we/i_cfg_wdata write component_count; only 9 is a valid format,
//   any other value gives zero results with bad_format set. Write it only
//   while no request is in flight.
//   Throughput: one tensor per cycle while o_out.ready is high, set by the four
//   front stages and the row of 36 root cells, each cell resolving one result bit per cycle.
//   The path from the accepting edge to o_out.valid holds 40 register
//   stages, the first loaded at the accepting edge.
//   Reset (i_rst_n low at a clock edge) empties every stage and sets
//   component_count to 9. When the receiver stalls, results hold in the
//   last cell and the row closes up bubbles behind it; i_in.ready drops only
//   once every stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module von_mises_effective_stress (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    vmes_in_if.sink                    i_in,
    vmes_out_if.source                 o_out,
    input  wire                        i_cfg_we,
    input  wire [vmes_pkg::CNT_W-1:0]  i_cfg_wdata
);
    import vmes_pkg::*;

    logic [CNT_W-1:0] r_component_count;

    logic                front_valid;
    t_cell_data          front_data;
    logic [OUT_BITS:0]   w_valid;
    logic [OUT_BITS:0]   w_ready;
    t_cell_data          w_data [OUT_BITS+1];
    t_cell_data          w_final;
    logic                w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_component_count <= VALID_COUNT;
        end else if (i_cfg_we) begin
            r_component_count <= i_cfg_wdata;
        end
    end

    vmes_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_s_xx  (i_in.s_xx),
        .i_s_xy  (i_in.s_xy),
        .i_s_xz  (i_in.s_xz),
        .i_s_yy  (i_in.s_yy),
        .i_s_yz  (i_in.s_yz),
        .i_s_zz  (i_in.s_zz),
        .i_bad   (r_component_count != VALID_COUNT),
        .i_last  (i_in.last_in),
        .o_valid (front_valid),
        .i_ready (w_ready[0]),
        .o_data  (front_data)
    );

    assign w_valid[0] = front_valid;
    assign w_data[0]  = front_data;

    for (genvar g = 0; g < OUT_BITS; g++) begin : g_cell
        vmes_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    assign w_ready[OUT_BITS] = o_out.ready;
    assign w_final = w_data[OUT_BITS];

    // flag saturation when the root is all ones and the next root value would not fit: remainder above 2*root
    assign w_sat = (&w_final.root) && (w_final.rem > REM_W'({w_final.root, 1'b0}));

    assign o_out.valid            = w_valid[OUT_BITS];
    assign o_out.effective_stress = w_final.bad ? '0 : w_final.root;
    assign o_out.saturated        = !w_final.bad && w_sat;
    assign o_out.bad_format       = w_final.bad;
    assign o_out.last_out         = w_final.last;

endmodule

`default_nettype wire

// File: rtl/vmes_checker.sv
// ----------------------------------------------------------------------------
// vmes_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vmes_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_out_valid,
    input  wire                           i_out_ready,
    input  wire [vmes_pkg::OUT_BITS-1:0]  i_stress,
    input  wire                           i_sat,
    input  wire                           i_bad,
    input  wire                           i_last
);
    import vmes_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_stress)
        && $stable(i_sat) && $stable(i_bad) && $stable(i_last))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad |-> i_stress == '0 && !i_sat)
        else $error("bad format result not zero");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_sat |-> &i_stress)
        else $error("saturated result not at maximum");

    // 32-bit components keep 3*J2 below 2^66, so the root stays below 2^33
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_stress[OUT_BITS-1:33] == '0 && !i_sat)
        else $error("root out of range");

endmodule

bind von_mises_effective_stress vmes_checker u_vmes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_stress    (o_out.effective_stress),
    .i_sat       (o_out.saturated),
    .i_bad       (o_out.bad_format),
    .i_last      (o_out.last_out)
);

`default_nettype wire
